### design/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg: shared types and constants of the triangle max path sum core
// Sizes of the column store, the value and sum widths, and the command that
// travels from the front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package tmps_pkg;

  // Triangle limits
  localparam int MAX_ROWS   = 512;
  localparam int VALUE_BITS = 16;

  // Port and datapath widths
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 26;
  localparam int COL_W   = $clog2(MAX_ROWS);
  localparam int ROW_W   = $clog2(MAX_ROWS + 1);

  // Low VALUE_BITS bits of an incoming value are used
  localparam logic [VALUE_W-1:0] VALUE_MASK =
    VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Command queue depth, a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Position class of one request
  typedef enum logic [2:0] {
    KIND_TOP,    // row 0: the value alone
    KIND_LEFT,   // column 0: sum above plus value
    KIND_RIGHT,  // last column: sum above-left plus value
    KIND_INNER,  // larger diagonal parent plus value
    KIND_DROP    // row beyond the limit: no update
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               end_row;
    logic               last;
    logic               ovf;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

### design/triangle_max_path_sum_core.sv
// ----------------------------------------------------------------------------
// triangle_max_path_sum_core: streaming maximum path sum of a number triangle
// Takes triangle elements in row-major order and returns the largest path sum
// of the last row when the element marked last arrives.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------
//   in      | in_valid / in_stall | value[15:0], last
//   out     | out_valid/out_stall | best_sum[25:0], overflow
//
// One element per cycle while in_stall is low; the marked element passes
// through the command queue, then the column update, which registers out_valid.
// The column store is read one column ahead each cycle, with a write bypass
// for the row-0 to row-1 turn.
// Reset clears counters, queue, update state and out_valid; the column store needs no clearing.
// in_stall rises when the two-entry command queue is full; it fills only
// while a finished result waits on out_stall.
// ----------------------------------------------------------------------------
module triangle_max_path_sum_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tmps_pkg::VALUE_W-1:0] value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tmps_pkg::SUM_W-1:0]   best_sum,
  output logic                         overflow
);
  import tmps_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // Intake and classification
  tmps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .last       (last),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  // Decouple intake from update
  tmps_cmd_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Column update and result
  tmps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_sum   (best_sum),
    .overflow   (overflow)
  );

endmodule

### design/tmps_ram.sv
// ----------------------------------------------------------------------------
// tmps_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns the
// contents before a write in the same cycle.
// ----------------------------------------------------------------------------
module tmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled and read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/tmps_front.sv
// ----------------------------------------------------------------------------
// tmps_front: request intake and position classification
// Tracks row and column of the next element, tags each request with its
// position class and pushes it into the command queue.
// ----------------------------------------------------------------------------
module tmps_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tmps_pkg::VALUE_W-1:0] value,
  input  logic                         last,
  output logic                         push,
  output tmps_pkg::cmd_t               push_cmd,
  input  logic                         queue_full
);
  import tmps_pkg::*;

  logic [ROW_W-1:0] row_index, row_index_next;
  logic [COL_W-1:0] column_index, column_index_next;
  logic             overflow_seen, overflow_seen_next;
  logic [ROW_W-1:0] col_ext;
  logic             drop;
  logic             end_row;
  kind_t            kind;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;
  assign col_ext  = ROW_W'(column_index);

  // Classify the request by its position
  always_comb begin
    drop    = (row_index == ROW_W'(MAX_ROWS));
    end_row = (col_ext == row_index);
    if (drop) begin
      kind = KIND_DROP;
    end else if (row_index == '0) begin
      kind = KIND_TOP;
    end else if (column_index == '0) begin
      kind = KIND_LEFT;
    end else if (end_row) begin
      kind = KIND_RIGHT;
    end else begin
      kind = KIND_INNER;
    end
  end

  assign push_cmd = '{kind:    kind,
                      end_row: end_row,
                      last:    last,
                      ovf:     overflow_seen || drop,
                      value:   value & VALUE_MASK};

  // Advance the position on each accepted request; a dropped one sets overflow, last restarts
  always_comb begin
    row_index_next     = row_index;
    column_index_next  = column_index;
    overflow_seen_next = overflow_seen;
    if (push) begin
      if (drop) begin
        overflow_seen_next = 1'b1;
      end else if (end_row) begin
        row_index_next    = row_index + ROW_W'(1);
        column_index_next = '0;
      end else begin
        column_index_next = column_index + COL_W'(1);
      end
      if (last) begin
        row_index_next     = '0;
        column_index_next  = '0;
        overflow_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index     <= '0;
      column_index  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      row_index     <= row_index_next;
      column_index  <= column_index_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

### design/tmps_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tmps_cmd_fifo: command queue between front end and back end
// Small register FIFO; full depends on the stored count only.
// ----------------------------------------------------------------------------
module tmps_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tmps_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tmps_pkg::cmd_t head_cmd
);
  import tmps_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head, head_next;
  logic [QPTR_W-1:0] tail, tail_next;
  logic [QCNT_W-1:0] count, count_next;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[head];

  // Advance pointers and count
  always_comb begin
    head_next  = pop  ? head + QPTR_W'(1) : head;
    tail_next  = push ? tail + QPTR_W'(1) : tail;
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("command queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("command queue popped while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + QCNT_W'(1))
    else $error("command queue count did not advance on push");
`endif

endmodule

### design/tmps_back.sv
// ----------------------------------------------------------------------------
// tmps_back: column update engine and result register; pops one command per
// cycle, a last one if no result waits, merges it with the prefetched column
// sum and left parent, writes the sum back, emits the row maximum on last.
// ----------------------------------------------------------------------------
module tmps_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  tmps_pkg::cmd_t             head_cmd,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tmps_pkg::SUM_W-1:0] best_sum,
  output logic                       overflow
);
  import tmps_pkg::*;

  logic [COL_W-1:0] next_col, next_col_next;
  logic [SUM_W-1:0] left_parent, left_parent_next;
  logic [SUM_W-1:0] row_best, row_best_next;
  logic [SUM_W-1:0] rd_data;
  logic [SUM_W-1:0] old_here;
  logic [SUM_W-1:0] parent;
  logic [SUM_W:0]   raw_sum;
  logic [SUM_W-1:0] sum;
  logic             wr_en;
  logic             byp_hit;
  logic [SUM_W-1:0] byp_data;
  logic             take_result;

  // Pop unless a result would overwrite one still waiting
  assign pop = head_valid && (!head_cmd.last || !out_valid || !out_stall);
  assign wr_en       = pop && (head_cmd.kind != KIND_DROP);
  assign take_result = pop && head_cmd.last;

  // Use last cycle's write when it hit the address being read
  assign old_here = byp_hit ? byp_data : rd_data;

  // Select parent and add with saturation
  always_comb begin
    case (head_cmd.kind)
      KIND_TOP:   parent = '0;
      KIND_LEFT:  parent = old_here;
      KIND_RIGHT: parent = left_parent;
      KIND_INNER: parent = (left_parent > old_here) ? left_parent : old_here;
      default:    parent = '0;
    endcase
    raw_sum = {1'b0, parent} + (SUM_W + 1)'(head_cmd.value);
    sum     = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
  end

  // Advance column, left parent and row maximum
  always_comb begin
    next_col_next    = next_col;
    left_parent_next = left_parent;
    row_best_next    = row_best;
    if (wr_en) begin
      left_parent_next = old_here;
      if (head_cmd.kind == KIND_TOP || head_cmd.kind == KIND_LEFT || sum > row_best) begin
        row_best_next = sum;
      end
      next_col_next = head_cmd.end_row ? '0 : next_col + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_col    <= '0;
      left_parent <= '0;
      row_best    <= '0;
      byp_hit     <= 1'b0;
    end else begin
      byp_hit <= wr_en && (next_col == next_col_next);
      if (take_result) begin
        next_col    <= '0;
        left_parent <= '0;
        row_best    <= '0;
      end else begin
        next_col    <= next_col_next;
        left_parent <= left_parent_next;
        row_best    <= row_best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= sum;
  end

  // Column store, read ahead at the next column every cycle
  tmps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS)
  ) u_column_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (next_col),
    .wr_data (sum),
    .rd_addr (next_col_next),
    .rd_data (rd_data)
  );

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_result) begin
      best_sum <= row_best_next;
      overflow <= head_cmd.ovf;
    end
  end

`ifndef NO_ASSERTIONS
  a_first_col: assert property (@(posedge clk) disable iff (rst)
    pop && (head_cmd.kind == KIND_TOP || head_cmd.kind == KIND_LEFT) |-> next_col == '0)
    else $error("row start request not at column 0");
  a_later_col: assert property (@(posedge clk) disable iff (rst)
    pop && (head_cmd.kind == KIND_RIGHT || head_cmd.kind == KIND_INNER) |->
    next_col != '0)
    else $error("inner or edge request at column 0");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    take_result |=> out_valid && next_col == '0 && row_best == '0)
    else $error("state not cleared after result");
`endif

endmodule
